>>> sv/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg
// Types, character codes and classification helpers for the token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

    typedef enum logic [2:0] {
        CLS_SEMI = 3'd0,
        CLS_OP   = 3'd1,
        CLS_NUM  = 3'd2,
        CLS_VAR  = 3'd3,
        CLS_UNK  = 3'd4
    } cls_t;

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    localparam int TDATA_OUT_W = 32;

    typedef struct packed {
        logic       last;
        logic [7:0] second_char;
        logic [7:0] first_char;
        logic [7:0] length;
        cls_t       cls;
    } tok_t;

    // up to two tokens per accepted character
    typedef struct packed {
        logic [1:0] count;
        tok_t       tok1;
        tok_t       tok0;
    } tok_pair_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

    function automatic cls_t punct_class(input logic [7:0] c);
        cls_t r;
        if (c == CH_SEMI) begin
            r = CLS_SEMI;
        end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
                     c == CH_EQ || c == CH_LT || c == CH_GT) begin
            r = CLS_OP;
        end else if (c == CH_UNDER) begin
            r = CLS_VAR;
        end else begin
            r = CLS_UNK;
        end
        return r;
    endfunction

    function automatic tok_t single_tok(input logic [7:0] c);
        tok_t t;
        t.cls         = punct_class(c);
        t.length      = 8'd1;
        t.first_char  = c;
        t.second_char = 8'd0;
        t.last        = 1'b0;
        return t;
    endfunction

endpackage

>>> sv/streaming_token_lexer_unit.sv
// ----------------------------------------------------------------------------
// streaming_token_lexer_unit
// Line lexer: one character in per transaction, classified tokens out.
//
//   channel   dir  tdata                     tlast
//   s_axis    in   ch                        end_of_line
//   m_axis    out  class/length/chars        last token of this character
//
// One character is accepted per cycle while s_axis_tready is high; its
// tokens are queued in the same cycle and leave one per cycle through a
// four-entry output queue while m_axis_tready is high.
// s_axis_tready drops while the queue holds three or more tokens.
// aresetn is synchronous, active low, and clears lexer state and the queue.
// ----------------------------------------------------------------------------
module streaming_token_lexer_unit #(
    parameter int MAX_TOKEN_LEN = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [stl_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
    // [2:0] token_class, [10:3] token_length, [18:11] first_char,
    // [26:19] second_char, [31:27] zero
    output logic        m_axis_tlast
);
    import stl_pkg::*;

    tok_pair_t pair;
    tok_t      head;
    logic      room;
    logic      accept;

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    stl_core #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .ch      (s_axis_tdata),
        .eol     (s_axis_tlast),
        .res     (pair)
    );

    stl_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (pair),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_tok   (head)
    );

    assign m_axis_tdata = {5'd0, head.second_char, head.first_char, head.length, head.cls};
    assign m_axis_tlast = head.last;

endmodule

>>> sv/stl_core.sv
// ----------------------------------------------------------------------------
// stl_core
// Lexer state and per-character token generation, at most two tokens a cycle.
// ----------------------------------------------------------------------------
module stl_core #(
    parameter int MAX_TOKEN_LEN = 255
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic [7:0]         ch,
    input  logic               eol,
    output stl_pkg::tok_pair_t res
);
    import stl_pkg::*;

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

    logic             held_valid_reg, held_valid_next;
    logic [7:0]       held_char_reg, held_char_next;
    logic [LEN_W-1:0] word_len_reg, word_len_next;
    logic             word_digits_reg, word_digits_next;
    logic             word_ident_reg, word_ident_next;
    logic [7:0]       word_first_reg, word_first_next;

    always_comb begin
        tok_t       slot [2];
        tok_t       t;
        logic [1:0] n;
        logic       done;
        logic [15:0] len_wide;

        held_valid_next  = held_valid_reg;
        held_char_next   = held_char_reg;
        word_len_next    = word_len_reg;
        word_digits_next = word_digits_reg;
        word_ident_next  = word_ident_reg;
        word_first_next  = word_first_reg;
        slot[0]  = '0;
        slot[1]  = '0;
        t        = '0;
        n        = 2'd0;
        done     = 1'b0;
        len_wide = 16'd0;

        if (held_valid_reg) begin
            held_valid_next = 1'b0;
            held_char_next  = 8'd0;
            if (ch == CH_EQ && (held_char_reg == CH_EQ || held_char_reg == CH_BANG ||
                                held_char_reg == CH_LT || held_char_reg == CH_GT)) begin
                t.cls         = CLS_OP;
                t.length      = 8'd2;
                t.first_char  = held_char_reg;
                t.second_char = ch;
                t.last        = 1'b0;
                slot[n[0]] = t;
                n = n + 2'd1;
                done = 1'b1;
            end else begin
                slot[n[0]] = single_tok(held_char_reg);
                n = n + 2'd1;
            end
        end

        // a held character implies an empty word, so a flush here is the
        // only word token this character can produce
        if (!done) begin
            if (is_space(ch)) begin
                // word flushed below
            end else if (is_punct(ch)) begin
                // word flushed below, then the punctuation itself
            end else begin
                if (word_len_next == '0) begin
                    word_first_next  = ch;
                    word_digits_next = is_digit(ch);
                    word_ident_next  = is_alpha(ch);
                end else begin
                    word_digits_next = word_digits_next && is_digit(ch);
                    word_ident_next  = word_ident_next && (is_alpha(ch) || is_digit(ch));
                end
                if (word_len_next < LEN_W'(MAX_TOKEN_LEN)) begin
                    word_len_next = word_len_next + LEN_W'(1);
                end
            end

            if (is_space(ch) || is_punct(ch) || eol) begin
                if (word_len_next != '0) begin
                    len_wide = 16'(word_len_next);
                    t.cls = word_digits_next ? CLS_NUM :
                            (word_ident_next ? CLS_VAR : CLS_UNK);
                    t.length      = (len_wide > 16'd255) ? 8'hFF : len_wide[7:0];
                    t.first_char  = word_first_next;
                    t.second_char = 8'd0;
                    t.last        = 1'b0;
                    slot[n[0]] = t;
                    n = n + 2'd1;
                    word_len_next    = '0;
                    word_digits_next = 1'b1;
                    word_ident_next  = 1'b1;
                    word_first_next  = 8'd0;
                end
            end

            if (is_punct(ch) && !is_space(ch)) begin
                if (eol) begin
                    slot[n[0]] = single_tok(ch);
                    n = n + 2'd1;
                end else begin
                    held_valid_next = 1'b1;
                    held_char_next  = ch;
                end
            end
        end

        if (n == 2'd2) begin
            slot[1].last = 1'b1;
        end else if (n == 2'd1) begin
            slot[0].last = 1'b1;
        end

        res.count = accept ? n : 2'd0;
        res.tok0  = slot[0];
        res.tok1  = slot[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg  <= 1'b0;
            held_char_reg   <= 8'd0;
            word_len_reg    <= '0;
            word_digits_reg <= 1'b1;
            word_ident_reg  <= 1'b1;
            word_first_reg  <= 8'd0;
        end else if (accept) begin
            held_valid_reg  <= held_valid_next;
            held_char_reg   <= held_char_next;
            word_len_reg    <= word_len_next;
            word_digits_reg <= word_digits_next;
            word_ident_reg  <= word_ident_next;
            word_first_reg  <= word_first_next;
        end
    end

endmodule

>>> sv/stl_out_queue.sv
// ----------------------------------------------------------------------------
// stl_out_queue
// Four-entry token queue, writes up to two tokens and reads one per cycle.
// ----------------------------------------------------------------------------
module stl_out_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  stl_pkg::tok_pair_t push,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output stl_pkg::tok_t      out_tok
);
    import stl_pkg::*;

    tok_t       mem [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != 3'd0;
    assign out_tok   = mem[rd_ptr_reg];
    // leave space for a two-token character
    assign room      = count_reg <= 3'd2;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push.count;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push.count} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.tok0;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_reg + 2'd1] <= push.tok1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
